[design/assert_macros.svh]
// assertion macros used by the line sequencer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset, sampled on clk
`define IVLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IVLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IVLS_ASSERT(lbl, prop, msg)
`define IVLS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/ivls_pkg.sv]
// shared constants, line kinds and result type for the line sequencer
`timescale 1ns / 1ps

package ivls_pkg;

    localparam int LINE_BYTES       = 322;
    localparam int FIELD_LAST_LINE  = 262;
    localparam int VBLANK_LAST_LINE = 22;
    localparam int IMAGE_HEIGHT     = 384;
    localparam int IMAGE_WIDTH      = 512;

    localparam int BITMAP_ROWS  = IMAGE_HEIGHT / 2;
    localparam int BORDER_LINES = (FIELD_LAST_LINE - VBLANK_LAST_LINE - BITMAP_ROWS) / 2;
    localparam int BORDER_END   = VBLANK_LAST_LINE + BORDER_LINES;
    localparam int BITMAP_END   = BORDER_END + BITMAP_ROWS;

    localparam int LINE_W   = 9;
    localparam int ROW_W    = 8;
    localparam int BYTES_W  = 10;
    localparam int OFFSET_W = 17;
    localparam int CFG_W    = 7;

    typedef enum logic [2:0] {
        KIND_BLANK    = 3'd0,
        KIND_EQUALIZE = 3'd1,
        KIND_VSYNC    = 3'd2,
        KIND_EQ_BLANK = 3'd3,
        KIND_BORDER   = 3'd4,
        KIND_PIXEL    = 3'd5
    } line_kind_t;

    typedef struct packed {
        line_kind_t            kind;
        logic [BYTES_W-1:0]    transfer_bytes;
        logic                  send_buffer;
        logic                  fetch_valid;
        logic                  fetch_buffer;
        logic [OFFSET_W-1:0]   fetch_offset;
        logic                  frame_done;
        logic [LINE_W-1:0]     line_number;
        logic                  field_odd;
    } result_t;

endpackage

[design/ivls_line_decode.sv]
// decodes one new line position into its line kind, byte count and row fetch
`timescale 1ns / 1ps

module ivls_line_decode
(
    input  logic [ivls_pkg::LINE_W-1:0]        line,
    input  logic                               field,
    input  logic [ivls_pkg::ROW_W-1:0]         row,
    input  logic                               hold_blank,
    input  logic signed [ivls_pkg::CFG_W-1:0]  interlace_offset,
    output logic [ivls_pkg::ROW_W-1:0]         row_next,
    output ivls_pkg::result_t                  result
);

    localparam logic [ivls_pkg::LINE_W-1:0] VBLANK_END_L =
        ivls_pkg::LINE_W'(ivls_pkg::VBLANK_LAST_LINE);
    localparam logic [ivls_pkg::LINE_W-1:0] BORDER_END_L =
        ivls_pkg::LINE_W'(ivls_pkg::BORDER_END);
    localparam logic [ivls_pkg::LINE_W-1:0] BITMAP_END_L =
        ivls_pkg::LINE_W'(ivls_pkg::BITMAP_END);
    localparam logic [ivls_pkg::LINE_W-1:0] DONE_LINE_L  =
        ivls_pkg::LINE_W'(ivls_pkg::BITMAP_END + 1);

    localparam int SUM_W = ivls_pkg::BYTES_W + 2;
    localparam logic signed [SUM_W-1:0] FULL_S = SUM_W'(ivls_pkg::LINE_BYTES);
    localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(ivls_pkg::LINE_BYTES / 2);
    localparam logic signed [SUM_W-1:0] ONE_HALF_S =
        SUM_W'(ivls_pkg::LINE_BYTES + ivls_pkg::LINE_BYTES / 2);
    localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'((1 << ivls_pkg::BYTES_W) - 1);

    logic signed [SUM_W-1:0]       off_s;
    logic signed [SUM_W-1:0]       bytes_s;
    logic [ivls_pkg::ROW_W-1:0]    row_plus;
    logic [ivls_pkg::ROW_W-1:0]    fetch_row;
    logic [31:0]                   offset_full;

    assign off_s    = SUM_W'(interlace_offset);
    assign row_plus = row + ivls_pkg::ROW_W'(1);

    always_comb
    begin
        result                = '0;
        result.kind           = ivls_pkg::KIND_BLANK;
        result.line_number    = line;
        result.field_odd      = field;
        bytes_s               = FULL_S;
        row_next              = row;
        fetch_row             = row;

        if (line <= VBLANK_END_L)
        begin
            if (line == ivls_pkg::LINE_W'(0))
            begin
                result.kind = ivls_pkg::KIND_BLANK;
                if (field)
                begin
                    bytes_s = HALF_S + off_s;
                end
            end
            else if (line <= ivls_pkg::LINE_W'(3))
            begin
                result.kind = ivls_pkg::KIND_EQUALIZE;
            end
            else if (line <= ivls_pkg::LINE_W'(6))
            begin
                result.kind = ivls_pkg::KIND_VSYNC;
            end
            else if (line <= ivls_pkg::LINE_W'(8))
            begin
                result.kind = ivls_pkg::KIND_EQUALIZE;
            end
            else if (line == ivls_pkg::LINE_W'(9))
            begin
                if (field)
                begin
                    result.kind = ivls_pkg::KIND_EQ_BLANK;
                    bytes_s     = ONE_HALF_S - off_s;
                end
                else
                begin
                    result.kind = ivls_pkg::KIND_EQUALIZE;
                end
            end
            else
            begin
                result.kind = ivls_pkg::KIND_BLANK;
            end
        end
        else if (line <= BORDER_END_L)
        begin
            if (!hold_blank)
            begin
                result.kind = ivls_pkg::KIND_BORDER;
                // prefetch the first row on the last top border line
                if (line == BORDER_END_L)
                begin
                    result.fetch_valid = 1'b1;
                end
            end
        end
        else if (line <= BITMAP_END_L)
        begin
            if (!hold_blank)
            begin
                result.kind        = ivls_pkg::KIND_PIXEL;
                result.send_buffer = row[0];
                row_next           = row_plus;
                fetch_row          = row_plus;
                // no fetch past the last bitmap row
                if (row_plus < ivls_pkg::ROW_W'(ivls_pkg::BITMAP_ROWS))
                begin
                    result.fetch_valid = 1'b1;
                end
            end
        end
        else
        begin
            result.frame_done = (line == DONE_LINE_L);
            result.kind       = hold_blank ? ivls_pkg::KIND_BLANK : ivls_pkg::KIND_BORDER;
        end

        offset_full = ((32'(fetch_row) * 32'd2 + 32'(field)) *
                       32'(ivls_pkg::IMAGE_WIDTH)) / 2;
        if (result.fetch_valid)
        begin
            result.fetch_buffer = fetch_row[0];
            result.fetch_offset = offset_full[ivls_pkg::OFFSET_W-1:0];
        end

        if (bytes_s < SUM_W'(0))
        begin
            result.transfer_bytes = '0;
        end
        else if (bytes_s > MAX_S)
        begin
            result.transfer_bytes = '1;
        end
        else
        begin
            result.transfer_bytes = bytes_s[ivls_pkg::BYTES_W-1:0];
        end
    end

endmodule

[design/interlaced_video_line_sequencer_top.sv]
// line sequencer top level: line, field and row counters with the result register
//
// usage: send one beat on in_valid/in_ready at the end of every scanline,
// carrying hold_blank. the block advances its line counter (wrapping once per
// field and toggling the field flag) and returns one result beat on
// out_valid/out_ready describing the next line: its kind, byte count, pixel
// buffer to send, an optional bitmap row fetch and the frame-done pulse.
// the result is registered: it is valid in the cycle after the input beat is taken.
// throughput: one beat per cycle while out_ready is high; the counter update
// and line decode sit between the counter registers and a single result register.
// a stalled receiver keeps the result register full; a new input beat is
// still taken in the cycle the held result is taken (in_ready = !out_valid
// or out_ready), otherwise in_ready drops until the result leaves.
// cfg_valid/cfg_ready write the signed interlace offset; cfg_ready is always
// high and writes are expected only while no line is in flight.
// reset: line counter at the last line of the field so the first beat gives
// line 0 of the odd field, row counter and offset cleared, output empty.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module interlaced_video_line_sequencer_top
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ivls_pkg::CFG_W-1:0]          cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                hold_blank,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          line_kind,
    output logic [ivls_pkg::BYTES_W-1:0]        transfer_bytes,
    output logic                                send_buffer,
    output logic                                fetch_valid,
    output logic                                fetch_buffer,
    output logic [ivls_pkg::OFFSET_W-1:0]       fetch_offset,
    output logic                                frame_done,
    output logic [ivls_pkg::LINE_W-1:0]         line_number,
    output logic                                field_odd
);

    localparam logic [ivls_pkg::LINE_W-1:0] LAST_LINE_L =
        ivls_pkg::LINE_W'(ivls_pkg::FIELD_LAST_LINE);

    logic [ivls_pkg::LINE_W-1:0]        line_count_reg;
    logic [ivls_pkg::LINE_W-1:0]        line_count_next;
    logic                               field_flag_reg;
    logic                               field_flag_next;
    logic [ivls_pkg::ROW_W-1:0]         row_count_reg;
    logic [ivls_pkg::ROW_W-1:0]         row_base;
    logic [ivls_pkg::ROW_W-1:0]         row_count_next;
    logic signed [ivls_pkg::CFG_W-1:0]  offset_reg;
    logic                               out_valid_reg;
    ivls_pkg::result_t                  result_reg;
    ivls_pkg::result_t                  result_next;
    logic                               in_beat;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;

    // next line position; the wrap starts a new field and clears the row count
    always_comb
    begin
        if (line_count_reg >= LAST_LINE_L)
        begin
            line_count_next = '0;
            field_flag_next = !field_flag_reg;
            row_base        = '0;
        end
        else
        begin
            line_count_next = line_count_reg + ivls_pkg::LINE_W'(1);
            field_flag_next = field_flag_reg;
            row_base        = row_count_reg;
        end
    end

    ivls_line_decode u_decode
    (
        .line             (line_count_next),
        .field            (field_flag_next),
        .row              (row_base),
        .hold_blank       (hold_blank),
        .interlace_offset (offset_reg),
        .row_next         (row_count_next),
        .result           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LAST_LINE_L;
            field_flag_reg <= 1'b0;
            row_count_reg  <= '0;
            offset_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
            if (in_beat)
            begin
                line_count_reg <= line_count_next;
                field_flag_reg <= field_flag_next;
                row_count_reg  <= row_count_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_kind      = result_reg.kind;
    assign transfer_bytes = result_reg.transfer_bytes;
    assign send_buffer    = result_reg.send_buffer;
    assign fetch_valid    = result_reg.fetch_valid;
    assign fetch_buffer   = result_reg.fetch_buffer;
    assign fetch_offset   = result_reg.fetch_offset;
    assign frame_done     = result_reg.frame_done;
    assign line_number    = result_reg.line_number;
    assign field_odd      = result_reg.field_odd;

    `IVLS_ASSERT(a_beat_gives_result, in_beat |=> out_valid_reg, "input beat without result")
    `IVLS_ASSERT_ALWAYS(a_line_in_field, line_count_reg <= LAST_LINE_L, "line counter out of field")
    `IVLS_ASSERT(a_done_line, (out_valid_reg && result_reg.frame_done) |-> (result_reg.line_number == ivls_pkg::LINE_W'(ivls_pkg::BITMAP_END + 1)), "frame done on wrong line")
    `IVLS_ASSERT(a_fetch_region, (out_valid_reg && result_reg.fetch_valid) |-> (result_reg.line_number >= ivls_pkg::LINE_W'(ivls_pkg::BORDER_END) && result_reg.line_number <= ivls_pkg::LINE_W'(ivls_pkg::BITMAP_END)), "fetch outside bitmap area")
    `IVLS_ASSERT(a_send_on_pixel, (out_valid_reg && result_reg.send_buffer) |-> (result_reg.kind == ivls_pkg::KIND_PIXEL), "buffer select on non-pixel line")

endmodule
